[sv/srg_pkg.sv]
package srg_pkg;

    localparam int COLS_DEF        = 32;
    localparam int VALUE_WIDTH_DEF = 64;

    localparam int ROW_W      = 16;
    localparam int COL_W      = 6;
    localparam int OCOL_W     = 5;
    localparam int KIND_W     = 2;
    localparam int NCOL_W     = 6;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 6;
    localparam int Q_DEPTH    = 2;

    localparam logic [CFG_IDX_W-1:0] REG_KIND     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    localparam logic [KIND_W-1:0] KIND_UNSIGNED1 = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SIGNED1   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SECOND    = 2'd2;

    localparam logic [NCOL_W-1:0] NUM_COLS_RST = 6'd32;
    localparam logic [ROW_W-1:0]  LAST_ROW     = 16'hFFFF;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [NCOL_W-1:0] num_cols;
    } t_cfg;

    typedef struct packed {
        logic             err;
        logic [ROW_W-1:0] row;
    } t_cmd;

    typedef struct packed {
        logic             vld;
        logic             err;
        logic             emit;
        logic             last;
        logic             wr;
        logic             sp;
        logic             sp_one;
        logic             sub;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_tok;

endpackage

[sv/srg_front.sv]
module srg_front (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    input  logic                             i_restart,
    output logic                             o_stall,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [srg_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [srg_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output srg_pkg::t_cfg                    o_cfg,
    output logic                             o_push,
    output srg_pkg::t_cmd                    o_cmd,
    input  logic                             i_full
);
    import srg_pkg::*;

    logic [KIND_W-1:0] r_kind;
    logic [NCOL_W-1:0] r_num_cols;
    logic [ROW_W-1:0]  r_row_cnt;
    logic              r_exhausted;
    logic [ROW_W-1:0]  n_row_cnt;
    logic              n_exhausted;
    logic [ROW_W-1:0]  cur_row;
    logic              cur_exh;

    assign o_stall     = i_full;
    assign o_cfg_ready = 1'b1;
    assign o_push      = i_valid && !i_full;
    assign o_cfg.kind     = r_kind;
    assign o_cfg.num_cols = r_num_cols;

    // restart takes effect before the item is classified
    always_comb begin
        cur_row = i_restart ? '0 : r_row_cnt;
        cur_exh = i_restart ? 1'b0 : r_exhausted;
        o_cmd.err = cur_exh;
        o_cmd.row = cur_exh ? '0 : cur_row;
        n_row_cnt   = r_row_cnt;
        n_exhausted = r_exhausted;
        if (o_push && !cur_exh) begin
            if (cur_row == LAST_ROW) begin
                n_row_cnt   = cur_row;
                n_exhausted = 1'b1;
            end else begin
                n_row_cnt   = cur_row + ROW_W'(1);
                n_exhausted = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_cnt   <= '0;
            r_exhausted <= 1'b0;
        end else begin
            r_row_cnt   <= n_row_cnt;
            r_exhausted <= n_exhausted;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind     <= KIND_UNSIGNED1;
            r_num_cols <= NUM_COLS_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_KIND:     r_kind     <= i_cfg_data[KIND_W-1:0];
                REG_NUM_COLS: r_num_cols <= i_cfg_data[NCOL_W-1:0];
                default: ;
            endcase
        end
    end

endmodule

[sv/srg_queue.sv]
module srg_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  srg_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output srg_pkg::t_cmd o_cmd,
    output logic          o_empty
);
    import srg_pkg::*;

    localparam int PTR_W = $clog2(Q_DEPTH);
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

[sv/srg_back.sv]
module srg_back #(
    parameter int COLS        = srg_pkg::COLS_DEF,
    parameter int VALUE_WIDTH = srg_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  srg_pkg::t_cfg                i_cfg,
    input  logic                         i_empty,
    input  srg_pkg::t_cmd                i_cmd,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [srg_pkg::ROW_W-1:0]    o_row_index,
    output logic [srg_pkg::OCOL_W-1:0]   o_col_index,
    output logic [VALUE_WIDTH-1:0]       o_value,
    output logic                         o_last,
    output logic                         o_error
);
    import srg_pkg::*;

    localparam int K_W  = $clog2(COLS + 1);
    localparam int A_W  = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int LO_W = VALUE_WIDTH / 2;
    localparam int HI_W = VALUE_WIDTH - LO_W;
    localparam int PL_W = ROW_W + LO_W;
    localparam int PH_W = ROW_W + HI_W;

    logic [VALUE_WIDTH-1:0] r_mem [COLS];

    logic             r_busy;
    logic             r_err;
    logic [K_W-1:0]   r_col;
    logic [ROW_W-1:0] r_row;

    logic [VALUE_WIDTH-1:0] r_rd;
    logic [VALUE_WIDTH-1:0] r_rd_d;

    t_tok                   r_t1;
    t_tok                   r_t2;
    t_tok                   r_t3;
    t_tok                   n_t1;
    logic [ROW_W-1:0]       r_m1;
    logic [ROW_W-1:0]       n_m1;
    logic [PL_W-1:0]        r_plo;
    logic [HI_W-1:0]        r_phi;
    logic [PH_W-1:0]        phi_full;
    logic [VALUE_WIDTH-1:0] r_base2;
    logic [VALUE_WIDTH-1:0] r_base3;
    logic [VALUE_WIDTH-1:0] r_prod;
    logic [VALUE_WIDTH-1:0] res_val;

    logic                   r_o_valid;
    logic [ROW_W-1:0]       r_o_row;
    logic [OCOL_W-1:0]      r_o_col;
    logic [VALUE_WIDTH-1:0] r_o_value;
    logic                   r_o_last;
    logic                   r_o_err;

    logic           adv;
    logic           start;
    logic           issue;
    logic [K_W-1:0] act_cols;
    logic [ROW_W-1:0] col_ext;

    assign adv   = !r_o_valid || !i_stall;
    // next row only once the previous one is fully written back
    assign start = !r_busy && !i_empty && !r_t1.vld && !r_t2.vld && !r_t3.vld;
    assign issue = r_busy && adv;
    assign o_pop = start;

    always_comb begin
        if (i_cfg.num_cols == '0) begin
            act_cols = K_W'(1);
        end else if (32'(i_cfg.num_cols) > COLS) begin
            act_cols = K_W'(COLS);
        end else begin
            act_cols = K_W'(i_cfg.num_cols);
        end
    end

    always_comb begin
        col_ext     = ROW_W'(r_col);
        n_t1.vld    = issue;
        n_t1.err    = r_err;
        n_t1.emit   = r_err || (r_col < act_cols);
        n_t1.last   = !r_err && ((r_col + K_W'(1)) == act_cols);
        n_t1.wr     = !r_err;
        n_t1.sp     = r_err || (r_col == '0) || (col_ext >= r_row);
        n_t1.sp_one = !r_err && (col_ext == r_row);
        n_t1.sub    = (i_cfg.kind == KIND_SIGNED1);
        n_t1.row    = r_err ? '0 : r_row;
        n_t1.col    = r_err ? '0 : COL_W'(r_col);
        // high kind bit selects the second kind (multiplier k)
        n_m1 = i_cfg.kind[1] ? col_ext : (r_row - ROW_W'(1));
    end

    // column sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (start) begin
            r_busy <= 1'b1;
        end else if (issue && (r_err || (r_col == K_W'(COLS - 1)))) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_col <= '0;
            r_row <= i_cmd.row;
            r_err <= i_cmd.err;
        end else if (issue) begin
            r_col <= r_col + K_W'(1);
        end
    end

    // previous row store: read ahead of the write-back, so reads always see the old row
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd   <= r_mem[r_col[A_W-1:0]];
            r_rd_d <= r_rd;
        end
        if (adv && r_t3.vld && r_t3.wr) begin
            r_mem[r_t3.col[A_W-1:0]] <= res_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t1 <= '0;
            r_t2 <= '0;
            r_t3 <= '0;
        end else if (adv) begin
            r_t1 <= n_t1;
            r_t2 <= r_t1;
            r_t3 <= r_t2;
        end
    end

    assign phi_full = PH_W'(r_m1) * PH_W'(r_rd[VALUE_WIDTH-1:LO_W]);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_m1    <= n_m1;
            r_plo   <= PL_W'(r_m1) * PL_W'(r_rd[LO_W-1:0]);
            r_phi   <= phi_full[HI_W-1:0];
            r_base2 <= r_rd_d;
            r_prod  <= VALUE_WIDTH'(r_plo) + {r_phi, {LO_W{1'b0}}};
            r_base3 <= r_base2;
        end
    end

    always_comb begin
        if (r_t3.sp) begin
            res_val = VALUE_WIDTH'(r_t3.sp_one);
        end else if (r_t3.sub) begin
            res_val = r_base3 - r_prod;
        end else begin
            res_val = r_base3 + r_prod;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (adv) begin
            r_o_valid <= r_t3.vld && r_t3.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_t3.vld && r_t3.emit) begin
            r_o_row   <= r_t3.row;
            r_o_col   <= r_t3.col[OCOL_W-1:0];
            r_o_value <= res_val;
            r_o_last  <= r_t3.last;
            r_o_err   <= r_t3.err;
        end
    end

    assign o_valid     = r_o_valid;
    assign o_row_index = r_o_row;
    assign o_col_index = r_o_col;
    assign o_value     = r_o_value;
    assign o_last      = r_o_last;
    assign o_error     = r_o_err;

endmodule

[sv/stirling_row_generator.sv]
// A request is queued and popped into the sweep, token pipeline and output register.
// Throughput: a row sweeps all COLS columns of the previous-row memory, one column
// per cycle while the output is not stalled, plus the multiply/add pipeline drain
// before the next row may read it; a counter-exhausted request issues one token.
// Reset: synchronous, active low; clears row counter, queue, pipeline and registers.
module stirling_row_generator #(
    parameter int COLS        = srg_pkg::COLS_DEF,
    parameter int VALUE_WIDTH = srg_pkg::VALUE_WIDTH_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic                           i_restart,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [srg_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [srg_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic [srg_pkg::ROW_W-1:0]      o_row_index,
    output logic [srg_pkg::OCOL_W-1:0]     o_col_index,
    output logic [VALUE_WIDTH-1:0]         o_value,
    output logic                           o_last,
    output logic                           o_error
);
    import srg_pkg::*;

    t_cfg cfg;
    t_cmd push_cmd;
    t_cmd pop_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    srg_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_restart   (i_restart),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (full)
    );

    srg_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_empty (empty)
    );

    srg_back #(
        .COLS        (COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_empty     (empty),
        .i_cmd       (pop_cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_row_index (o_row_index),
        .o_col_index (o_col_index),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_error     (o_error)
    );

endmodule

[sv/srg_checker.sv]
module srg_checker #(
    parameter int VALUE_WIDTH = srg_pkg::VALUE_WIDTH_DEF
) (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         o_valid,
    input logic                         i_stall,
    input logic [srg_pkg::ROW_W-1:0]    o_row_index,
    input logic [srg_pkg::OCOL_W-1:0]   o_col_index,
    input logic [VALUE_WIDTH-1:0]       o_value,
    input logic                         o_last,
    input logic                         o_error
);
    import srg_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_value) && $stable(o_row_index)
            && $stable(o_col_index) && $stable(o_last) && $stable(o_error))
        else $error("result changed while stalled");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_error |-> o_row_index == '0 && o_col_index == '0
            && o_value == '0 && !o_last)
        else $error("error item carries nonzero fields");

    // column 0 is zero for every row past row 0 (row below 32 keeps the column unambiguous)
    a_col0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_error && o_col_index == '0 && o_row_index != '0
            && o_row_index < ROW_W'(32) |-> o_value == '0)
        else $error("column 0 nonzero past row 0");

    a_row_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && o_last |=> !o_valid || o_error || o_col_index == '0)
        else $error("row did not restart at column 0");

endmodule

bind stirling_row_generator srg_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_srg_checker (.*);

[verif/tb.sv]
module tb;
    import srg_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NCOLS   = COLS_DEF;
    localparam int VALUE_W = VALUE_WIDTH_DEF;
    // rows keep sweeping the full memory after the last shown column
    localparam int SWEEP_CYCLES = NCOLS + 16;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 28;

    localparam logic [KIND_W-1:0]    KIND_ALIAS  = KIND_SECOND | KIND_SIGNED1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    typedef struct {
        logic [ROW_W-1:0]   row;
        logic [OCOL_W-1:0]  col;
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               err;
    } t_row_entry;

    class t_row_scoreboard;
        logic [VALUE_W-1:0] row_mem [NCOLS];
        logic [ROW_W-1:0]   next_row;
        bit                 spent;
        logic [KIND_W-1:0]  kind;
        logic [NCOL_W-1:0]  num_cols;
        t_row_entry         pending [$];
        int                 errors;

        function new();
            foreach (row_mem[k]) row_mem[k] = '0;
            next_row = '0;
            spent    = 1'b0;
            kind     = KIND_UNSIGNED1;
            num_cols = NUM_COLS_RST;
            errors   = 0;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_KIND)
                kind = data[KIND_W-1:0];
            else if (idx == REG_NUM_COLS)
                num_cols = data[NCOL_W-1:0];
        endfunction

        // builds the whole next row, then queues the columns that get shown
        function void note_request(logic restart);
            logic [VALUE_W-1:0] fresh [NCOLS];
            logic [VALUE_W-1:0] mult;
            logic [VALUE_W-1:0] prod;
            int unsigned        n;
            int unsigned        shown;
            t_row_entry         e;

            if (restart) begin
                next_row = '0;
                spent    = 1'b0;
            end
            if (spent) begin
                e.row   = '0;
                e.col   = '0;
                e.value = '0;
                e.last  = 1'b0;
                e.err   = 1'b1;
                pending.push_back(e);
                return;
            end
            n = next_row;
            for (int k = 0; k < NCOLS; k++) begin
                if (k == n) begin
                    fresh[k] = VALUE_W'(1);
                end else if (k == 0 || k > n) begin
                    fresh[k] = '0;
                end else begin
                    mult = kind[1] ? VALUE_W'(k) : VALUE_W'(n) - 1'b1;
                    prod = mult * row_mem[k];
                    if (kind == KIND_SIGNED1)
                        fresh[k] = row_mem[k-1] - prod;
                    else
                        fresh[k] = row_mem[k-1] + prod;
                end
            end
            row_mem = fresh;
            shown = (num_cols == 0) ? 1 : ((num_cols > NCOLS) ? NCOLS : num_cols);
            for (int k = 0; k < shown; k++) begin
                e.row   = ROW_W'(n);
                e.col   = OCOL_W'(k);
                e.value = row_mem[k];
                e.last  = (k + 1 == shown);
                e.err   = 1'b0;
                pending.push_back(e);
            end
            if (next_row == LAST_ROW)
                spent = 1'b1;
            else
                next_row = next_row + 1'b1;
        endfunction

        function void match_field(string name, logic [VALUE_W-1:0] want,
                                  logic [VALUE_W-1:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_entry(logic [ROW_W-1:0] row, logic [OCOL_W-1:0] col,
                                  logic [VALUE_W-1:0] value, logic last, logic err);
            t_row_entry e;

            if (pending.size() == 0) begin
                $error("unexpected item: row %0d col %0d err %0b", row, col, err);
                errors++;
                return;
            end
            e = pending.pop_front();
            match_field("row_index", e.row, row);
            match_field("col_index", e.col, col);
            match_field("value", e.value, value);
            match_field("last", e.last, last);
            match_field("error", e.err, err);
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    logic                    i_clk       = 1'b0;
    logic                    i_rst_n     = 1'b0;
    logic                    i_valid     = 1'b0;
    logic                    i_restart   = 1'b0;
    logic                    i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]   i_cfg_data  = '0;
    logic                    i_stall     = 1'b0;
    logic                    o_stall;
    logic                    o_cfg_ready;
    logic                    o_valid;
    logic [ROW_W-1:0]        o_row_index;
    logic [OCOL_W-1:0]       o_col_index;
    logic [VALUE_W-1:0]      o_value;
    logic                    o_last;
    logic                    o_error;

    bit              send_gaps = 1'b0;
    bit              recv_gaps = 1'b0;
    t_row_scoreboard sb;

    stirling_row_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_restart   (i_restart),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_row_index (o_row_index),
        .o_col_index (o_col_index),
        .o_value     (o_value),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= recv_gaps && ($urandom_range(99) < 13);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall)
                sb.check_entry(o_row_index, o_col_index, o_value, o_last, o_error);
            if (i_valid && !o_stall)
                sb.note_request(i_restart);
            if (i_cfg_valid && o_cfg_ready)
                sb.set_register(i_cfg_index, i_cfg_data);
        end
    end

    // leaves i_valid high on return; caller lowers it at the end of a burst
    task automatic request_row(input logic restart);
        while (send_gaps && $urandom_range(99) < 13) begin
            i_valid   <= 1'b0;
            i_restart <= 1'($urandom_range(1));
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_restart <= restart;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic program_reg(input logic [CFG_IDX_W-1:0] idx,
                               input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (SWEEP_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        #(20_000_000);
        $display("tb: done, errors");
        $finish;
    end

    initial begin
        logic [KIND_W-1:0]     kinds [4];
        logic [CFG_DATA_W-1:0] cols;

        kinds = '{KIND_UNSIGNED1, KIND_SIGNED1, KIND_SECOND, KIND_ALIAS};
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset defaults: unsigned first kind, all columns
        request_row(1'b1);
        request_row(1'b0);
        request_row(1'b0);
        settle();

        // zero columns acts as one
        program_reg(REG_KIND, CFG_DATA_W'(KIND_SIGNED1));
        program_reg(REG_NUM_COLS, '0);
        request_row(1'b0);
        request_row(1'b0);
        settle();

        // kind three acts as second kind, oversize column count clamps
        program_reg(REG_KIND, CFG_DATA_W'(KIND_ALIAS));
        program_reg(REG_NUM_COLS, '1);
        request_row(1'b1);
        repeat (3) request_row(1'b0);
        settle();

        // writes past the register list change nothing
        program_reg(REG_SPARE_2, '1);
        program_reg(REG_SPARE_3, '1);
        program_reg(REG_KIND, CFG_DATA_W'(KIND_SECOND));
        program_reg(REG_NUM_COLS, NUM_COLS_RST);
        request_row(1'b1);
        repeat (4) request_row(1'b0);
        settle();

        // random rows; the first phase runs without gaps on either side
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            case (p)
                1:       cols = CFG_DATA_W'(1);
                2:       cols = NUM_COLS_RST;
                3:       cols = '0;
                4:       cols = '1;
                default: cols = CFG_DATA_W'($urandom_range(1, NCOLS));
            endcase
            program_reg(REG_KIND, CFG_DATA_W'(kinds[p % 4]));
            program_reg(REG_NUM_COLS, cols);
            send_gaps = (p != 0);
            recv_gaps = (p != 0);
            for (int i = 0; i < PHASE_ITEMS; i++)
                request_row($urandom_range(39) == 0);
            settle();
        end

        // short burst with gaps: restarts mixed with plain requests
        send_gaps = 1'b1;
        recv_gaps = 1'b1;
        program_reg(REG_KIND, CFG_DATA_W'(KIND_SIGNED1));
        program_reg(REG_NUM_COLS, CFG_DATA_W'(1));
        request_row(1'b1);
        request_row(1'b0);
        request_row(1'b0);
        request_row(1'b1);
        request_row(1'b0);
        settle();

        if (sb.errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
